[sv/mclr_pkg.sv]
// package for the multi-channel load cell reader
// shared constants, state types and the lane control struct; no dependencies
package mclr_pkg;

  localparam int MAX_CHANNELS = 4;
  localparam int CH_W = 2;
  localparam int CNT_W = 3;
  localparam int DIV_STEPS = 32;
  localparam logic [23:0] MAX24 = 24'hFF_FFFF;
  localparam logic [4:0] FRAME_BITS = 5'd24;

  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [2:0] REG_TELE_DIVISOR = 3'd1;
  localparam logic [2:0] REG_TARE_SAMPLES = 3'd2;
  localparam logic [2:0] REG_TARE_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_STALE_TICKS = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW,
    PH_EXTRA
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_WB,
    ST_OUT
  } seq_t;

  typedef struct packed {
    logic        shift_clr;
    logic        shift_en;
    logic        sum_clr;
    logic        sum_add;
    logic        div_start;
    logic        div_tare;
    logic        div_step;
    logic        off_wr;
    logic [24:0] den;
  } lane_ctl_t;

endpackage

[sv/mclr_lane.sv]
// one channel lane: serial shift register, tare offset and sum, iterative divider
// depends on mclr_pkg
module mclr_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  mclr_pkg::lane_ctl_t ctl,
  input  logic                active,
  input  logic                dout,
  output logic signed [23:0]  raw_value,
  output logic signed [24:0]  offset_counts,
  output logic signed [15:0]  tele_value,
  output logic                saturated
);
  import mclr_pkg::*;

  logic [23:0] shift_r, shift_nxt;
  logic signed [23:0] offset_r, offset_nxt;
  logic signed [31:0] sum_r, sum_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [24:0] den_r, den_nxt;
  logic neg_r, neg_nxt;
  logic signed [31:0] num;
  logic [25:0] trial;
  logic ge;
  logic [23:0] q24;

  assign raw_value = shift_r;
  assign offset_counts = 25'(raw_value) - 25'(offset_r);
  assign trial = {rem_r, quo_r[31]};
  assign ge = trial >= {1'b0, den_r};
  assign q24 = neg_r ? 24'(-quo_r[23:0]) : quo_r[23:0];

  always_comb begin
    num = ctl.div_tare ? sum_r : 32'(offset_counts);
    shift_nxt = shift_r;
    offset_nxt = offset_r;
    sum_nxt = sum_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    neg_nxt = neg_r;
    if (ctl.shift_clr) begin
      shift_nxt = '0;
    end else if (ctl.shift_en && active) begin
      shift_nxt = {shift_r[22:0], dout};
    end
    if (ctl.sum_clr) begin
      sum_nxt = (ctl.sum_add && active) ? 32'(raw_value) : '0;
    end else if (ctl.sum_add && active) begin
      sum_nxt = sum_r + 32'(raw_value);
    end
    if (ctl.off_wr && active) begin
      offset_nxt = q24;
    end
    if (ctl.div_start) begin
      rem_nxt = '0;
      quo_nxt = num[31] ? 32'(-num) : num;
      neg_nxt = num[31];
      den_nxt = ctl.den;
    end else if (ctl.div_step) begin
      rem_nxt = ge ? 25'(trial - {1'b0, den_r}) : trial[24:0];
      quo_nxt = {quo_r[30:0], ge};
    end
  end

  always_comb begin
    saturated = 1'b0;
    if (neg_r) begin
      if (quo_r > 32'd32768) begin
        saturated = 1'b1;
        tele_value = 16'sh8000;
      end else begin
        tele_value = 16'(-quo_r[15:0]);
      end
    end else begin
      if (quo_r > 32'd32767) begin
        saturated = 1'b1;
        tele_value = 16'sh7FFF;
      end else begin
        tele_value = quo_r[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      offset_r <= '0;
      sum_r <= '0;
    end else begin
      shift_r <= shift_nxt;
      offset_r <= offset_nxt;
      sum_r <= sum_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

endmodule

[sv/multi_channel_load_cell_reader.sv]
// top level: tick sequencer, tare control, four lanes and the result merge
// depends on mclr_pkg and mclr_lane
// One word is one half-period tick of the shared converter clock. A plain tick
// gives one word out. A tick that ends a frame outside a tare, or that ends a tare
// with frames summed, runs the lane dividers (ST_PREP, ST_DIV), for a tare also writes
// the offsets (ST_WB), and then hands out its words in ST_OUT, where an output stall holds it.
// All lanes divide at once, one quotient bit per cycle; the merge stage then hands out
// one result word per active channel for a sample and one status word for a tare.
module multi_channel_load_cell_reader (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [24:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [3:0]          in_dout_lines,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_sck,
  output logic                out_stalled,
  output logic                out_tared,
  output logic                out_sample_valid,
  output logic [1:0]          out_channel,
  output logic signed [23:0]  out_raw_value,
  output logic signed [24:0]  out_offset_counts,
  output logic signed [15:0]  out_tele_value,
  output logic                out_saturated,
  output logic                out_last
);
  import mclr_pkg::*;

  logic [2:0] chan_cnt_r;
  logic [24:0] divisor_r;
  logic [7:0] tare_samples_r;
  logic [23:0] timeout_r, stale_r;

  seq_t st_r, st_nxt;
  phase_t ph_r, ph_nxt;
  logic [4:0] bc_r, bc_nxt;
  logic [7:0] frames_r, frames_nxt;
  logic [23:0] timer_r, timer_nxt, idle_r, idle_nxt;
  logic tared_r, tared_nxt, taring_r, taring_nxt;
  logic sck_r, sck_nxt, stalled_r, stalled_nxt;
  logic emit_r, emit_nxt, tdiv_r, tdiv_nxt;
  logic [24:0] den_r, den_nxt;
  logic [5:0] step_r, step_nxt;
  logic [CH_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] n_act;
  logic [3:0] mask;
  logic taring_m;
  logic [7:0] frames_m, frames_inc, samples;
  logic [23:0] timer_m;
  logic accept;
  lane_ctl_t ctl;

  logic signed [23:0] l_raw [MAX_CHANNELS];
  logic signed [24:0] l_cnt [MAX_CHANNELS];
  logic signed [15:0] l_tele [MAX_CHANNELS];
  logic l_sat [MAX_CHANNELS];

  assign n_act = (chan_cnt_r == 3'd0) ? 3'd1 :
                 (chan_cnt_r > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : chan_cnt_r;
  assign mask = 4'((5'd1 << n_act) - 5'd1);
  assign samples = (tare_samples_r == 8'd0) ? 8'd1 : tare_samples_r;
  assign accept = in_valid && !in_stall;
  assign in_stall = st_r != ST_IDLE;
  assign taring_m = in_mode || taring_r;
  assign frames_m = in_mode ? 8'd0 : frames_r;
  assign timer_m = in_mode ? 24'd0 : timer_r;
  assign frames_inc = (frames_m == 8'd255) ? frames_m : frames_m + 8'd1;

  always_comb begin
    st_nxt = st_r;
    ph_nxt = ph_r;
    bc_nxt = bc_r;
    frames_nxt = frames_r;
    timer_nxt = timer_r;
    idle_nxt = idle_r;
    tared_nxt = tared_r;
    taring_nxt = taring_r;
    sck_nxt = sck_r;
    stalled_nxt = stalled_r;
    emit_nxt = emit_r;
    tdiv_nxt = tdiv_r;
    den_nxt = den_r;
    step_nxt = step_r;
    idx_nxt = idx_r;
    ctl = '0;
    ctl.den = den_r;
    ctl.div_tare = tdiv_r;
    unique case (st_r)
      ST_IDLE: begin
        if (accept) begin
          ctl.sum_clr = in_mode;
          taring_nxt = taring_m;
          frames_nxt = frames_m;
          timer_nxt = (taring_m && timer_m < MAX24) ? timer_m + 24'd1 : timer_m;
          idle_nxt = (idle_r < MAX24) ? idle_r + 24'd1 : idle_r;
          emit_nxt = 1'b0;
          tdiv_nxt = 1'b0;
          sck_nxt = 1'b0;
          idx_nxt = '0;
          st_nxt = ST_OUT;
          unique case (ph_r)
            PH_IDLE: begin
              if (taring_m && timer_nxt >= timeout_r) begin
                taring_nxt = 1'b0;
                if (frames_m == 8'd0) begin
                  tared_nxt = 1'b0;
                end else begin
                  tared_nxt = 1'b1;
                  tdiv_nxt = 1'b1;
                  den_nxt = 25'(frames_m);
                  st_nxt = ST_PREP;
                end
              end
              if ((in_dout_lines & mask) == 4'd0) begin
                ctl.shift_clr = 1'b1;
                bc_nxt = '0;
                sck_nxt = 1'b1;
                ph_nxt = PH_HIGH;
              end
            end
            PH_HIGH: begin
              ctl.shift_en = 1'b1;
              bc_nxt = bc_r + 5'd1;
              ph_nxt = PH_LOW;
            end
            PH_LOW: begin
              sck_nxt = 1'b1;
              ph_nxt = (bc_r >= FRAME_BITS) ? PH_EXTRA : PH_HIGH;
            end
            PH_EXTRA: begin
              ph_nxt = PH_IDLE;
              idle_nxt = '0;
              if (!taring_m) begin
                emit_nxt = 1'b1;
                den_nxt = (divisor_r == 25'd0) ? 25'd1 : divisor_r;
                st_nxt = ST_PREP;
              end else begin
                ctl.sum_add = 1'b1;
                frames_nxt = frames_inc;
                if (frames_inc >= samples) begin
                  taring_nxt = 1'b0;
                  tared_nxt = 1'b1;
                  tdiv_nxt = 1'b1;
                  den_nxt = 25'(frames_inc);
                  st_nxt = ST_PREP;
                end
              end
            end
            default: ph_nxt = PH_IDLE;
          endcase
          stalled_nxt = idle_nxt > stale_r;
        end
      end
      ST_PREP: begin
        ctl.div_start = 1'b1;
        step_nxt = '0;
        st_nxt = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'(DIV_STEPS - 1)) begin
          st_nxt = tdiv_r ? ST_WB : ST_OUT;
        end
      end
      ST_WB: begin
        ctl.off_wr = 1'b1;
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) begin
          if (out_last) begin
            st_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    mclr_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .active        (mask[g]),
      .dout          (in_dout_lines[g]),
      .raw_value     (l_raw[g]),
      .offset_counts (l_cnt[g]),
      .tele_value    (l_tele[g]),
      .saturated     (l_sat[g])
    );
  end

  assign out_valid = st_r == ST_OUT;
  assign out_sck = sck_r;
  assign out_stalled = stalled_r;
  assign out_tared = tared_r;
  assign out_sample_valid = emit_r;
  assign out_channel = emit_r ? idx_r : '0;
  assign out_raw_value = emit_r ? l_raw[idx_r] : '0;
  assign out_offset_counts = emit_r ? l_cnt[idx_r] : '0;
  assign out_tele_value = emit_r ? l_tele[idx_r] : '0;
  assign out_saturated = emit_r ? l_sat[idx_r] : 1'b0;
  assign out_last = !emit_r || (3'(idx_r) == n_act - 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= 3'd1;
      divisor_r <= 25'd1;
      tare_samples_r <= 8'd8;
      timeout_r <= 24'd1000000;
      stale_r <= 24'd200000;
      st_r <= ST_IDLE;
      ph_r <= PH_IDLE;
      bc_r <= '0;
      frames_r <= '0;
      timer_r <= '0;
      idle_r <= '0;
      tared_r <= 1'b0;
      taring_r <= 1'b0;
      step_r <= '0;
      idx_r <= '0;
      emit_r <= 1'b0;
      tdiv_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_CHANNEL_COUNT: chan_cnt_r <= cfg_wdata[2:0];
          REG_TELE_DIVISOR: divisor_r <= cfg_wdata;
          REG_TARE_SAMPLES: tare_samples_r <= cfg_wdata[7:0];
          REG_TARE_TIMEOUT: timeout_r <= cfg_wdata[23:0];
          REG_STALE_TICKS: stale_r <= cfg_wdata[23:0];
          default: ;
        endcase
      end
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      bc_r <= bc_nxt;
      frames_r <= frames_nxt;
      timer_r <= timer_nxt;
      idle_r <= idle_nxt;
      tared_r <= tared_nxt;
      taring_r <= taring_nxt;
      step_r <= step_nxt;
      idx_r <= idx_nxt;
      emit_r <= emit_nxt;
      tdiv_r <= tdiv_nxt;
    end
    sck_r <= sck_nxt;
    stalled_r <= stalled_nxt;
    den_r <= den_nxt;
  end

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV && step_r == 6'(DIV_STEPS - 1)) |=> (st_r == ST_WB || st_r == ST_OUT))
    else $error("divider did not finish on time");

  a_blank_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sample_valid) |-> out_last)
    else $error("status word not marked last");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// testbench for multi_channel_load_cell_reader: directed table, then random frames and noise
// predicts every result word with a local model of the tick sequencer; depends on mclr_pkg
module testbench;
  import mclr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [24:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [3:0] in_dout_lines = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_sck, out_stalled, out_tared, out_sample_valid, out_saturated, out_last;
  logic [1:0] out_channel;
  logic signed [23:0] out_raw_value;
  logic signed [24:0] out_offset_counts;
  logic signed [15:0] out_tele_value;

  always #4 clk = ~clk;

  multi_channel_load_cell_reader dut (.*);

  typedef struct packed {
    logic sck, stalled, tared, sample_valid;
    logic [1:0] channel;
    logic [23:0] raw_value;
    logic [24:0] offset_counts;
    logic [15:0] tele_value;
    logic saturated, last;
  } reading_t;

  typedef struct {
    logic mode;
    logic [3:0] lines;
    logic chk;
    reading_t first;
  } stim_row_t;

  reading_t expected_q[$];
  int errors = 0;
  longint cycles = 0;

  // model state
  int unsigned m_chans, m_div, m_samples, m_timeout, m_stale;
  phase_t m_phase;
  int unsigned m_bits, m_frames, m_timer, m_idle;
  logic [23:0] m_shift[MAX_CHANNELS];
  int m_offset[MAX_CHANNELS];
  longint m_sum[MAX_CHANNELS];
  logic m_tared, m_taring;

  function automatic int sext24(logic [23:0] v);
    return int'(signed'(v));
  endfunction

  function automatic int unsigned active_chans();
    if (m_chans == 0) return 1;
    if (m_chans > MAX_CHANNELS) return MAX_CHANNELS;
    return m_chans;
  endfunction

  function automatic void end_tare(int unsigned n);
    if (m_frames == 0) m_tared = 1'b0;
    else begin
      for (int i = 0; i < n; i++) m_offset[i] = int'(m_sum[i] / longint'(m_frames));
      m_tared = 1'b1;
    end
    m_taring = 1'b0;
  endfunction

  function automatic void predict_tick(logic mode, logic [3:0] lines);
    int unsigned n, smp;
    logic [3:0] mask;
    logic sck, done, stl;
    reading_t r;
    longint dv, cnt, tv;
    n = active_chans();
    mask = 4'((1 << n) - 1);
    smp = (m_samples == 0) ? 1 : m_samples;
    sck = 1'b0;
    done = 1'b0;
    if (mode) begin
      for (int i = 0; i < MAX_CHANNELS; i++) m_sum[i] = 0;
      m_frames = 0;
      m_timer = 0;
      m_taring = 1'b1;
    end
    if (m_taring && m_timer < 24'hFFFFFF) m_timer++;
    if (m_idle < 24'hFFFFFF) m_idle++;
    case (m_phase)
      PH_IDLE: begin
        if (m_taring && m_timer >= m_timeout) end_tare(n);
        if ((lines & mask) == 0) begin
          for (int i = 0; i < MAX_CHANNELS; i++) m_shift[i] = '0;
          m_bits = 0;
          sck = 1'b1;
          m_phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        for (int i = 0; i < n; i++) m_shift[i] = {m_shift[i][22:0], lines[i]};
        m_bits = (m_bits + 1) & 31;
        m_phase = PH_LOW;
      end
      PH_LOW: begin
        sck = 1'b1;
        m_phase = (m_bits >= 24) ? PH_EXTRA : PH_HIGH;
      end
      default: begin
        m_phase = PH_IDLE;
        done = 1'b1;
        m_idle = 0;
      end
    endcase
    stl = m_idle > m_stale;
    if (done && !m_taring) begin
      dv = (m_div == 0) ? 1 : m_div;
      for (int i = 0; i < n; i++) begin
        cnt = longint'(sext24(m_shift[i])) - m_offset[i];
        tv = cnt / dv;
        r = '0;
        if (tv > 32767) begin tv = 32767; r.saturated = 1'b1; end
        if (tv < -32768) begin tv = -32768; r.saturated = 1'b1; end
        r.sck = sck; r.stalled = stl; r.tared = m_tared; r.sample_valid = 1'b1;
        r.channel = 2'(i); r.raw_value = m_shift[i]; r.offset_counts = 25'(cnt);
        r.tele_value = 16'(tv); r.last = (i + 1 == n);
        expected_q.push_back(r);
      end
      return;
    end
    if (done) begin
      for (int i = 0; i < n; i++) m_sum[i] += sext24(m_shift[i]);
      if (m_frames < 255) m_frames++;
      if (m_frames >= smp) end_tare(n);
    end
    r = '0;
    r.sck = sck; r.stalled = stl; r.tared = m_tared; r.last = 1'b1;
    expected_q.push_back(r);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd2_000_000) begin
      $display("[multi_channel_load_cell_reader] ERROR");
      $finish;
    end
  end

  // receiver: stall pattern and checking
  int stall_mode = 0;
  always @(posedge clk) begin
    reading_t got, exp_r;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_sck, out_stalled, out_tared, out_sample_valid, out_channel, out_raw_value,
              out_offset_counts, out_tele_value, out_saturated, out_last};
      if (expected_q.size() == 0) begin
        $error("unexpected word");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.sck !== exp_r.sck) begin $error("sck exp %0d got %0d", exp_r.sck, got.sck); errors++; end
        if (got.stalled !== exp_r.stalled) begin
          $error("stalled exp %0d got %0d", exp_r.stalled, got.stalled); errors++; end
        if (got.tared !== exp_r.tared) begin
          $error("tared exp %0d got %0d", exp_r.tared, got.tared); errors++; end
        if (got.sample_valid !== exp_r.sample_valid) begin
          $error("sample_valid exp %0d got %0d", exp_r.sample_valid, got.sample_valid); errors++; end
        if (got.channel !== exp_r.channel) begin
          $error("channel exp %0d got %0d", exp_r.channel, got.channel); errors++; end
        if (got.raw_value !== exp_r.raw_value) begin
          $error("raw_value exp %0h got %0h", exp_r.raw_value, got.raw_value); errors++; end
        if (got.offset_counts !== exp_r.offset_counts) begin
          $error("offset_counts exp %0h got %0h", exp_r.offset_counts, got.offset_counts);
          errors++; end
        if (got.tele_value !== exp_r.tele_value) begin
          $error("tele_value exp %0h got %0h", exp_r.tele_value, got.tele_value); errors++; end
        if (got.saturated !== exp_r.saturated) begin
          $error("saturated exp %0d got %0d", exp_r.saturated, got.saturated); errors++; end
        if (got.last !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, got.last); errors++; end
      end
    end
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  int burst_left = 0;

  task automatic send_tick(logic mode, logic [3:0] lines);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_dout_lines <= lines;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tick(mode, lines);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [24:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CHANNEL_COUNT: m_chans = val[2:0];
      REG_TELE_DIVISOR: m_div = val;
      REG_TARE_SAMPLES: m_samples = val[7:0];
      REG_TARE_TIMEOUT: m_timeout = val[23:0];
      REG_STALE_TICKS: m_stale = val[23:0];
      default: ;
    endcase
  endtask

  // full frame: start tick, 24 high/low pairs, extra pulse and completion
  task automatic send_frame(logic [23:0] w[MAX_CHANNELS], logic tare_req, int unsigned noise);
    logic [3:0] l;
    send_tick(tare_req, 4'h0);
    for (int b = 23; b >= 0; b--) begin
      for (int c = 0; c < MAX_CHANNELS; c++) l[c] = w[c][b];
      send_tick(1'b0, l);
      send_tick(1'b0, ($urandom_range(0, 99) < noise) ? 4'($urandom) : l);
    end
    send_tick(1'b0, 4'($urandom));
    send_tick(1'b0, 4'($urandom));
  endtask

  task automatic random_frame(logic tare_req);
    logic [23:0] w[MAX_CHANNELS];
    for (int c = 0; c < MAX_CHANNELS; c++)
      case ($urandom_range(0, 4))
        0: w[c] = 24'h7FFFFF;
        1: w[c] = 24'h800000;
        default: w[c] = 24'($urandom);
      endcase
    send_frame(w, tare_req, 10);
  endtask

  stim_row_t rows[$];

  initial begin
    reading_t z;
    logic [23:0] w[MAX_CHANNELS];
    m_chans = 1; m_div = 1; m_samples = 8; m_timeout = 1000000; m_stale = 200000;
    m_phase = PH_IDLE; m_bits = 0; m_frames = 0; m_timer = 0; m_idle = 0;
    m_tared = 1'b0; m_taring = 1'b0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      m_shift[i] = '0; m_offset[i] = 0; m_sum[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: lines high hold off the frame, then a start, a sample and noise
    z = '0; z.last = 1'b1;
    rows.push_back('{1'b0, 4'h1, 1'b1, z});
    rows.push_back('{1'b0, 4'hF, 1'b1, z});
    rows.push_back('{1'b0, 4'hE, 1'b0, z});
    rows.push_back('{1'b1, 4'h1, 1'b0, z});
    rows.push_back('{1'b0, 4'hF, 1'b0, z});
    rows.push_back('{1'b0, 4'h0, 1'b0, z});
    foreach (rows[k]) begin
      if (rows[k].chk && expected_q.size() == 0) begin
        send_tick(rows[k].mode, rows[k].lines);
        if (expected_q[expected_q.size() - 1] !== rows[k].first) begin
          $error("table row %0d prediction mismatch", k); errors++;
        end
      end else send_tick(rows[k].mode, rows[k].lines);
    end
    drain();
    // short timeout ends the pending tare once its first frame is summed
    write_reg(REG_TARE_TIMEOUT, 25'd1);
    write_reg(REG_CHANNEL_COUNT, 25'd4);
    write_reg(REG_STALE_TICKS, 25'd30);
    for (int c = 0; c < MAX_CHANNELS; c++) w[c] = (c[0]) ? 24'h7FFFFF : 24'h800000;
    send_frame(w, 1'b0, 0);
    drain();
    write_reg(REG_TELE_DIVISOR, 25'h1000000);
    write_reg(REG_TARE_SAMPLES, 25'd0);
    write_reg(REG_TARE_TIMEOUT, 25'hFFFFFF);
    write_reg(REG_STALE_TICKS, 25'hFFFFFF);
    send_frame(w, 1'b1, 0);
    send_frame(w, 1'b0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_CHANNEL_COUNT, 25'(ph == 5 ? 7 : ph % 5));
      write_reg(REG_TELE_DIVISOR, (ph % 3 == 0) ? 25'd1 : 25'($urandom_range(0, 300)));
      write_reg(REG_TARE_SAMPLES, (ph == 4) ? 25'd255 : 25'($urandom_range(1, 3)));
      write_reg(REG_TARE_TIMEOUT, 25'($urandom_range(ph == 2 ? 0 : 40, 400)));
      write_reg(REG_STALE_TICKS, 25'($urandom_range(0, 80)));
      for (int f = 0; f < 1; f++) random_frame($urandom_range(0, 5) == 0);
      if (ph == 3) begin
        for (int t = 0; t < 20; t++) send_tick(1'($urandom), 4'($urandom));
        while (expected_q.size() != 0) @(posedge clk);
        for (int t = 0; t < 5; t++) send_tick(1'b0, 4'($urandom));
      end
      drain();
    end

    if (errors == 0) $display("[multi_channel_load_cell_reader] OK");
    else $display("[multi_channel_load_cell_reader] ERROR");
    $finish;
  end
endmodule
